[rtl/shlex_pkg.sv]
package shlex_pkg;

  // Result kinds
  localparam logic [2:0] KIND_BYTE   = 3'd0;
  localparam logic [2:0] KIND_STREND = 3'd1;
  localparam logic [2:0] KIND_PIPE   = 3'd2;
  localparam logic [2:0] KIND_LREDIR = 3'd3;
  localparam logic [2:0] KIND_RREDIR = 3'd4;
  localparam logic [2:0] KIND_END    = 3'd5;
  localparam logic [2:0] KIND_ERROR  = 3'd6;

  // Characters the lexer reacts to
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_PIPE   = 8'h7C;

  // Result queue depth
  localparam int unsigned RQ_DEPTH = 4;
  localparam int unsigned RQ_AW    = $clog2(RQ_DEPTH);

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data;
    logic       last;
  } result_t;

  // Results caused by one byte: count and up to two results in order
  typedef struct packed {
    logic [1:0] num;
    result_t    r0;
    result_t    r1;
  } step_t;

endpackage

[rtl/shlex_step.sv]
// Token decoder: classifies one byte against the lexer mode and holds the mode.
module shlex_step (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic [7:0]            char_in,
  output shlex_pkg::step_t      step
);

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_WORD,
    MODE_SQUOTE,
    MODE_DQUOTE
  } mode_t;

  mode_t      mode;
  mode_t      mode_next;
  logic       blank;
  logic       special;
  logic [2:0] special_kind;
  logic [7:0] delim;

  // Byte classes
  always_comb begin
    blank = (char_in == shlex_pkg::CH_SPACE) || (char_in == shlex_pkg::CH_TAB) ||
            (char_in == shlex_pkg::CH_VT) || (char_in == shlex_pkg::CH_FF) ||
            (char_in == shlex_pkg::CH_CR);
    special      = 1'b1;
    special_kind = shlex_pkg::KIND_END;
    unique case (char_in)
      shlex_pkg::CH_PIPE: special_kind = shlex_pkg::KIND_PIPE;
      shlex_pkg::CH_LT:   special_kind = shlex_pkg::KIND_LREDIR;
      shlex_pkg::CH_GT:   special_kind = shlex_pkg::KIND_RREDIR;
      shlex_pkg::CH_NUL:  special_kind = shlex_pkg::KIND_END;
      default:            special      = 1'b0;
    endcase
    delim = (mode == MODE_SQUOTE) ? shlex_pkg::CH_SQUOTE : shlex_pkg::CH_DQUOTE;
  end

  // Results and next mode
  always_comb begin
    mode_next    = mode;
    step.num     = 2'd0;
    step.r0.kind = shlex_pkg::KIND_BYTE;
    step.r0.data = 8'h00;
    step.r0.last = 1'b1;
    step.r1.kind = shlex_pkg::KIND_BYTE;
    step.r1.data = 8'h00;
    step.r1.last = 1'b1;
    unique case (mode)
      MODE_IDLE: begin
        priority if (blank || char_in == shlex_pkg::CH_LF) begin
          step.num = 2'd0;
        end else if (special) begin
          step.num     = 2'd1;
          step.r0.kind = special_kind;
        end else if (char_in == shlex_pkg::CH_SQUOTE) begin
          mode_next = MODE_SQUOTE;
        end else if (char_in == shlex_pkg::CH_DQUOTE) begin
          mode_next = MODE_DQUOTE;
        end else begin
          step.num     = 2'd1;
          step.r0.data = char_in;
          mode_next    = MODE_WORD;
        end
      end
      MODE_WORD: begin
        priority if (blank) begin
          step.num     = 2'd1;
          step.r0.kind = shlex_pkg::KIND_STREND;
          mode_next    = MODE_IDLE;
        end else if (special) begin
          // word end followed by the special token
          step.num     = 2'd2;
          step.r0.kind = shlex_pkg::KIND_STREND;
          step.r0.last = 1'b0;
          step.r1.kind = special_kind;
          mode_next    = MODE_IDLE;
        end else if (char_in == shlex_pkg::CH_SQUOTE) begin
          mode_next = MODE_SQUOTE;
        end else if (char_in == shlex_pkg::CH_DQUOTE) begin
          mode_next = MODE_DQUOTE;
        end else begin
          step.num     = 2'd1;
          step.r0.data = char_in;
        end
      end
      MODE_SQUOTE, MODE_DQUOTE: begin
        priority if (char_in == shlex_pkg::CH_NUL) begin
          // unterminated quote
          step.num     = 2'd1;
          step.r0.kind = shlex_pkg::KIND_ERROR;
          mode_next    = MODE_IDLE;
        end else if (char_in == delim) begin
          mode_next = MODE_WORD;
        end else begin
          step.num     = 2'd1;
          step.r0.data = char_in;
        end
      end
      default: mode_next = MODE_IDLE;
    endcase
  end

  // Mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_IDLE;
    end else if (en) begin
      mode <= mode_next;
    end
  end

endmodule

[rtl/shell_command_lexer.sv]
// Streaming shell lexer. One byte of the command line is taken per transfer and
// turns into zero, one or two results, delivered one per cycle while out_ready
// is high, through a four-entry result queue. A byte is accepted every cycle
// while the output side keeps up; a byte that closes a word with a pipe,
// redirect or end token yields two results and so occupies the single output
// port for both. A byte passes the input register, then the result queue,
// before its first result is shown. Blanks and newlines in idle mode, and
// opening or closing quote bytes, produce no result.
module shell_command_lexer (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] char_in,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] kind,
  output logic [7:0] byte_out,
  output logic       last
);

  localparam logic [shlex_pkg::RQ_AW:0] RQ_FULL = (shlex_pkg::RQ_AW + 1)'(shlex_pkg::RQ_DEPTH);
  localparam logic [shlex_pkg::RQ_AW:0] RQ_ROOM = (shlex_pkg::RQ_AW + 1)'(shlex_pkg::RQ_DEPTH - 2);

  logic                       s1_valid;
  logic [7:0]                 s1_char;
  logic                       advance;
  logic                       pop;
  shlex_pkg::step_t           step;

  shlex_pkg::result_t         rq [shlex_pkg::RQ_DEPTH];
  logic [shlex_pkg::RQ_AW-1:0] wr_ptr;
  logic [shlex_pkg::RQ_AW-1:0] rd_ptr;
  logic [shlex_pkg::RQ_AW:0]   count;
  logic [shlex_pkg::RQ_AW:0]   count_next;

  // Handshake: the held byte moves on when the queue has room for two results
  assign pop       = out_valid && out_ready;
  assign advance   = s1_valid && ((count <= RQ_ROOM) || ((count == RQ_ROOM + 1'b1) && pop));
  assign in_ready  = !s1_valid || advance;
  assign out_valid = (count != '0);

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      s1_char <= char_in;
    end
  end

  shlex_step u_step (
    .clk     (clk),
    .rst     (rst),
    .en      (advance),
    .char_in (s1_char),
    .step    (step)
  );

  // Result queue
  always_comb begin
    count_next = count;
    if (advance) begin
      count_next = count_next + {{(shlex_pkg::RQ_AW - 1){1'b0}}, step.num};
    end
    if (pop) begin
      count_next = count_next - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (advance) begin
        wr_ptr <= wr_ptr + step.num[shlex_pkg::RQ_AW-1:0];
      end
    end
    if (advance && step.num != 2'd0) begin
      rq[wr_ptr] <= step.r0;
    end
    if (advance && step.num == 2'd2) begin
      rq[wr_ptr + 1'b1] <= step.r1;
    end
  end

  assign kind     = rq[rd_ptr].kind;
  assign byte_out = rq[rd_ptr].data;
  assign last     = rq[rd_ptr].last;

`ifndef SYNTHESIS
  a_rq_bound: assert property (@(posedge clk) disable iff (rst) count <= RQ_FULL)
    else $error("result queue overflow");

  a_stall_held: assert property (@(posedge clk) disable iff (rst) !in_ready |-> s1_valid)
    else $error("input stalled with empty input register");

  a_result_shown: assert property (@(posedge clk) disable iff (rst)
    (advance && step.num != 2'd0) |=> out_valid)
    else $error("decoded result not presented");

  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (kind <= shlex_pkg::KIND_ERROR))
    else $error("result kind out of range");

  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !last) |-> (kind == shlex_pkg::KIND_STREND))
    else $error("non-final result is not a string end");
`endif

endmodule
